// ----- rtl/i2cbm_pkg.sv -----
`default_nettype none

package i2cbm_pkg;

   // Width of the tick counter that times each wait.
   localparam int DELAY_WIDTH = 16;
   // Width of every configuration register.
   localparam int CFG_WIDTH = 16;
   // Width of the configuration register index.
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int BYTE_WIDTH = 8;
   localparam int BIT_INDEX_WIDTH = 4;
   localparam int REQ_TYPE_WIDTH = 2;

   // Register reset values.
   localparam logic [CFG_WIDTH-1:0] BIT_PERIOD_RESET = CFG_WIDTH'(10);
   localparam logic [CFG_WIDTH-1:0] START_HOLD_RESET = CFG_WIDTH'(5);
   localparam logic [CFG_WIDTH-1:0] STOP_HOLD_RESET = CFG_WIDTH'(5);
   localparam logic [CFG_WIDTH-1:0] STOP_RELEASE_RESET = CFG_WIDTH'(10);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_PERIOD = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_HOLD = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_HOLD = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STOP_RELEASE = CSR_INDEX_WIDTH'(3);

   // Command codes.
   typedef enum logic [REQ_TYPE_WIDTH-1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

endpackage

`default_nettype wire

// ----- rtl/i2c_bit_level_master_core.sv -----
`default_nettype none

// Bit-level I2C master. Every clock, unless the request side is stalled, the
// block takes one request carrying a time tick, the sampled SDA level and an
// optional command (start, stop, write byte or read byte), and returns one
// result with the SCL and SDA drive levels (1 released, 0 pulled low), a busy
// flag, a one-result done pulse, the byte of the last finished read and the
// ACK bit sampled by the last write. A command offered while a previous one is
// still running is dropped. Phase lengths are counted in ticks and come from
// four 16-bit registers: bit period, start hold, stop hold and stop release;
// half of a bit period is the period shifted right by one. It takes one
// request per clock while the request side is not stalled. A request is
// registered in an input stage and the sequencer then writes its result into
// the result register, from which it is offered. A stalled result holds the
// input stage, and the request side is stalled only while both the input
// stage and the result register are full. Registers should be written only
// while no request is in flight.
module i2c_bit_level_master_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Configuration port
   input  wire logic                                 csr_wr_en,
   input  wire logic [i2cbm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [i2cbm_pkg::CFG_WIDTH-1:0]       csr_wdata,
   // Request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_tick,
   input  wire logic                                 req_sda_in,
   input  wire logic                                 req_cmd_valid,
   input  wire logic [i2cbm_pkg::REQ_TYPE_WIDTH-1:0]  req_type,
   input  wire logic [i2cbm_pkg::BYTE_WIDTH-1:0]      req_write_data,
   input  wire logic                                 req_ack_to_send,
   // Result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_scl_out,
   output logic                                      rsp_sda_out,
   output logic                                      rsp_busy_res,
   output logic                                      rsp_done_res,
   output logic [i2cbm_pkg::BYTE_WIDTH-1:0]           rsp_read_data,
   output logic                                      rsp_ack_received
);

   import i2cbm_pkg::*;

   localparam int CMP_WIDTH = (DELAY_WIDTH > CFG_WIDTH) ? DELAY_WIDTH : CFG_WIDTH;
   localparam logic [DELAY_WIDTH-1:0] COUNT_MAX = {DELAY_WIDTH{1'b1}};

   // Sequencer phases. Each non-idle phase is a wait counted in ticks.
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_START_HOLD,
      PH_STOP_A,
      PH_STOP_B,
      PH_STOP_C,
      PH_TX_LOW,
      PH_TX_SETUP,
      PH_TX_HIGH,
      PH_RX_LOW,
      PH_RX_FIRST,
      PH_RX_SECOND
   } phase_type;

   // One registered request.
   typedef struct packed {
      logic                      tick;
      logic                      sda_in;
      logic                      cmd_valid;
      logic [REQ_TYPE_WIDTH-1:0] req_type;
      logic [BYTE_WIDTH-1:0]     write_data;
      logic                      ack_to_send;
   } item_type;

   // Configuration registers.
   logic [CFG_WIDTH-1:0] bit_period_ff;
   logic [CFG_WIDTH-1:0] start_hold_ff;
   logic [CFG_WIDTH-1:0] stop_hold_ff;
   logic [CFG_WIDTH-1:0] stop_release_ff;

   // Input stage.
   logic     s1_valid_ff;
   item_type s1_item_ff;

   // Sequencer state; these registers are also the result payload.
   phase_type                  phase_ff, phase_in;
   logic [DELAY_WIDTH-1:0]     count_ff, count_in;
   logic [BIT_INDEX_WIDTH-1:0] bit_index_ff, bit_index_in;
   logic [BYTE_WIDTH-1:0]      shift_ff, shift_in;
   logic                       scl_ff, scl_in;
   logic                       sda_ff, sda_in;
   logic                       ack_flag_ff, ack_flag_in;
   logic                       ack_choice_ff, ack_choice_in;
   logic                       read_mode_ff, read_mode_in;
   logic [BYTE_WIDTH-1:0]      read_reg_ff, read_reg_in;
   logic                       done_ff, done_in;
   logic                       rsp_valid_ff;

   logic                       out_ready;
   logic                       fire;
   logic [CFG_WIDTH-1:0]       half_period;
   logic [CFG_WIDTH-1:0]       wait_len;
   logic                       count_run;
   logic [DELAY_WIDTH-1:0]     count_step;
   logic                       wait_over;
   logic [BIT_INDEX_WIDTH-1:0] bit_index_inc;

   // The result register can take a new result when empty or being drained.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff   <= BIT_PERIOD_RESET;
         start_hold_ff   <= START_HOLD_RESET;
         stop_hold_ff    <= STOP_HOLD_RESET;
         stop_release_ff <= STOP_RELEASE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BIT_PERIOD:   bit_period_ff   <= csr_wdata;
            CSR_START_HOLD:   start_hold_ff   <= csr_wdata;
            CSR_STOP_HOLD:    stop_hold_ff    <= csr_wdata;
            CSR_STOP_RELEASE: stop_release_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage: loads whenever it is empty or its request moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         s1_item_ff <= '{tick:        req_tick,
                         sda_in:      req_sda_in,
                         cmd_valid:   req_cmd_valid,
                         req_type:    req_type,
                         write_data:  req_write_data,
                         ack_to_send: req_ack_to_send};
      end
   end

   assign half_period = bit_period_ff >> 1;

   // Length of the wait that the current phase stands for.
   always_comb begin
      case (phase_ff)
         PH_START_HOLD: wait_len = start_hold_ff;
         PH_STOP_A:     wait_len = bit_period_ff;
         PH_STOP_B:     wait_len = stop_hold_ff;
         PH_STOP_C:     wait_len = stop_release_ff;
         PH_TX_HIGH:    wait_len = bit_period_ff;
         PH_RX_LOW:     wait_len = bit_period_ff;
         default:       wait_len = half_period;
      endcase
   end

   // The counter counts ticks up to the wait length and saturates at its top.
   assign count_run = s1_item_ff.tick
                      && (CMP_WIDTH'(count_ff) < CMP_WIDTH'(wait_len))
                      && (count_ff != COUNT_MAX);
   assign count_step = count_run ? DELAY_WIDTH'(count_ff + 1'b1) : count_ff;
   assign wait_over  = (CMP_WIDTH'(count_step) >= CMP_WIDTH'(wait_len))
                       || (count_step == COUNT_MAX);
   assign bit_index_inc = BIT_INDEX_WIDTH'(bit_index_ff + 1'b1);

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      ack_flag_in   = ack_flag_ff;
      ack_choice_in = ack_choice_ff;
      read_mode_in  = read_mode_ff;
      read_reg_in   = read_reg_ff;
      done_in       = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (s1_item_ff.cmd_valid) begin
            count_in = '0;
            case (cmd_type'(s1_item_ff.req_type))
               CMD_START: begin
                  scl_in   = 1'b1;
                  sda_in   = 1'b0;
                  phase_in = PH_START_HOLD;
               end
               CMD_STOP: begin
                  sda_in   = 1'b0;
                  phase_in = PH_STOP_A;
               end
               CMD_WRITE: begin
                  read_mode_in = 1'b0;
                  shift_in     = s1_item_ff.write_data;
                  bit_index_in = '0;
                  scl_in       = 1'b0;
                  phase_in     = PH_TX_LOW;
               end
               default: begin
                  read_mode_in  = 1'b1;
                  ack_choice_in = s1_item_ff.ack_to_send;
                  shift_in      = '0;
                  bit_index_in  = '0;
                  sda_in        = 1'b1;
                  phase_in      = PH_RX_LOW;
               end
            endcase
         end
      end else begin
         count_in = count_step;
         if (wait_over) begin
            count_in = '0;
            case (phase_ff)
               PH_START_HOLD: begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
               PH_STOP_A: begin
                  scl_in   = 1'b1;
                  phase_in = PH_STOP_B;
               end
               PH_STOP_B: begin
                  sda_in   = 1'b1;
                  phase_in = PH_STOP_C;
               end
               PH_STOP_C: begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
               PH_TX_LOW: begin
                  // In a read this sends the ACK or NACK bit.
                  sda_in   = read_mode_ff ? ack_choice_ff : shift_ff[BYTE_WIDTH-1];
                  phase_in = PH_TX_SETUP;
               end
               PH_TX_SETUP: begin
                  scl_in   = 1'b1;
                  phase_in = PH_TX_HIGH;
               end
               PH_TX_HIGH: begin
                  scl_in = 1'b0;
                  if (read_mode_ff) begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end else begin
                     shift_in     = {shift_ff[BYTE_WIDTH-2:0], 1'b0};
                     bit_index_in = bit_index_inc;
                     if (bit_index_inc < BIT_INDEX_WIDTH'(BYTE_WIDTH)) begin
                        phase_in = PH_TX_LOW;
                     end else begin
                        // Byte sent: release SDA for the slave's ACK.
                        sda_in   = 1'b1;
                        phase_in = PH_RX_LOW;
                     end
                  end
               end
               PH_RX_LOW: begin
                  scl_in   = 1'b1;
                  phase_in = PH_RX_FIRST;
               end
               PH_RX_FIRST: begin
                  if (read_mode_ff) begin
                     shift_in = {shift_ff[BYTE_WIDTH-2:0], s1_item_ff.sda_in};
                  end else begin
                     ack_flag_in = s1_item_ff.sda_in;
                  end
                  phase_in = PH_RX_SECOND;
               end
               PH_RX_SECOND: begin
                  scl_in = 1'b0;
                  if (!read_mode_ff) begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end else begin
                     bit_index_in = bit_index_inc;
                     if (bit_index_inc < BIT_INDEX_WIDTH'(BYTE_WIDTH)) begin
                        sda_in   = 1'b1;
                        phase_in = PH_RX_LOW;
                     end else begin
                        // Byte complete: publish it and send the ACK bit.
                        read_reg_in = shift_ff;
                        phase_in    = PH_TX_LOW;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Sequencer and result register advance together, once per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= '0;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_flag_ff   <= 1'b0;
         ack_choice_ff <= 1'b0;
         read_mode_ff  <= 1'b0;
         read_reg_ff   <= '0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff      <= phase_in;
            count_ff      <= count_in;
            bit_index_ff  <= bit_index_in;
            shift_ff      <= shift_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            ack_flag_ff   <= ack_flag_in;
            ack_choice_ff <= ack_choice_in;
            read_mode_ff  <= read_mode_in;
            read_reg_ff   <= read_reg_in;
            done_ff       <= done_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_out      = scl_ff;
   assign rsp_sda_out      = sda_ff;
   assign rsp_busy_res     = (phase_ff != PH_IDLE);
   assign rsp_done_res     = done_ff;
   assign rsp_read_data    = read_reg_ff;
   assign rsp_ack_received = ack_flag_ff;

endmodule

`default_nettype wire

// ----- rtl/i2cbm_checker.sv -----
`default_nettype none

module i2cbm_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_stall,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   input  wire logic                                 rsp_scl_out,
   input  wire logic                                 rsp_sda_out,
   input  wire logic                                 rsp_busy_res,
   input  wire logic                                 rsp_done_res,
   input  wire logic [i2cbm_pkg::BYTE_WIDTH-1:0]      rsp_read_data,
   input  wire logic                                 rsp_ack_received
);

   import i2cbm_pkg::*;

   logic [BYTE_WIDTH-1:0] last_read_ff;

   // Read byte of the most recently delivered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_read_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         last_read_ff <= rsp_read_data;
      end
   end

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scl_out)
         && $stable(rsp_sda_out) && $stable(rsp_busy_res) && $stable(rsp_done_res)
         && $stable(rsp_read_data) && $stable(rsp_ack_received))
      else $error("stalled result changed");

   // Requests back up only when a result is waiting and held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while result side free");

   // A finished command always leaves the master idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while busy");

   // The read byte only changes while a command is running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_read_data == last_read_ff)
      else $error("read data changed while idle");

   // Nothing is presented right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind i2c_bit_level_master_core i2cbm_checker u_i2cbm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_scl_out      (rsp_scl_out),
   .rsp_sda_out      (rsp_sda_out),
   .rsp_busy_res     (rsp_busy_res),
   .rsp_done_res     (rsp_done_res),
   .rsp_read_data    (rsp_read_data),
   .rsp_ack_received (rsp_ack_received)
);

`default_nettype wire
